FILE: rtl/dmpwm_pkg.sv
// Shared constants, types and the duty-to-magnitude helper for the dual motor PWM drive.
// Standalone package, no dependencies.
package dmpwm_pkg;

    localparam int COUNT_WIDTH    = 24;
    localparam int DUTY_FRAC_BITS = 14;
    localparam int DUTY_WIDTH     = 16;

    // Duty arithmetic needs room for +/-ONE as well as the raw 16-bit field
    localparam int DUTY_EXT_W = (DUTY_WIDTH > DUTY_FRAC_BITS + 2) ? DUTY_WIDTH
                                                                  : DUTY_FRAC_BITS + 2;
    localparam int MAG_W  = DUTY_FRAC_BITS + 1;
    localparam int PROD_W = COUNT_WIDTH + MAG_W;

    localparam logic signed [DUTY_EXT_W-1:0] DUTY_ONE = DUTY_EXT_W'(1 << DUTY_FRAC_BITS);

    localparam logic [COUNT_WIDTH-1:0] PERIOD_TOP_RESET = COUNT_WIDTH'(49999);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_DUTY = 1'b1;

    typedef struct packed {
        logic             rev;
        logic [MAG_W-1:0] mag;
    } t_wheel_cmd;

    // Saturate the duty to [-ONE, ONE] and split it into a direction pin and an
    // unsigned duty, where reverse duty d drives ONE + d.
    function automatic t_wheel_cmd duty_to_cmd(input logic signed [DUTY_WIDTH-1:0] duty);
        logic signed [DUTY_EXT_W-1:0] d_ext;
        logic signed [DUTY_EXT_W-1:0] d_sum;
        t_wheel_cmd                   cmd;
        d_ext = DUTY_EXT_W'(duty);
        d_sum = d_ext + DUTY_ONE;
        if (d_ext > DUTY_ONE) begin
            cmd.rev = 1'b0;
            cmd.mag = DUTY_ONE[MAG_W-1:0];
        end else if (d_ext >= 0) begin
            cmd.rev = 1'b0;
            cmd.mag = d_ext[MAG_W-1:0];
        end else if (d_ext < -DUTY_ONE) begin
            cmd.rev = 1'b1;
            cmd.mag = '0;
        end else begin
            cmd.rev = 1'b1;
            cmd.mag = d_sum[MAG_W-1:0];
        end
        return cmd;
    endfunction

endpackage

FILE: rtl/dual_motor_pwm_with_direction_unit.sv
// Top level of the dual motor PWM drive: input register, state update and result register.
// Depends on dmpwm_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item: either a counter
//   tick (operation = 0) or a new pair of signed Q1.14 duties (operation = 1).
//   Every item produces exactly one result on the output channel
//   (o_out_valid / i_out_ready): both PWM levels, both direction pins and the
//   active compare values, all as they stand after the item.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes period_top; it is
//   always ready and must only be used while the block is idle.
//   An accepted item goes from the input register through the state update to
//   the result register. Throughput: one item per cycle while the receiver takes
//   results, set by the combinational update (one 24x15 multiply per wheel).
//   Stalls: when the receiver holds i_out_ready low the result register holds,
//   the input register can still take one more item, then o_in_ready drops.
//   Reset (synchronous, active low): counter, compares and pins go to zero,
//   period_top returns to 49999, both channels empty.
module dual_motor_pwm_with_direction_unit
    import dmpwm_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic signed [DUTY_WIDTH-1:0] i_left_duty,
    input  logic signed [DUTY_WIDTH-1:0] i_right_duty,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_left_pwm,
    output logic                         o_right_pwm,
    output logic                         o_left_reverse,
    output logic                         o_right_reverse,
    output logic [COUNT_WIDTH-1:0]       o_left_compare,
    output logic [COUNT_WIDTH-1:0]       o_right_compare,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [COUNT_WIDTH-1:0]       i_cfg_period_top
);

    // input register
    logic                         r_in_valid;
    logic                         r_op;
    logic signed [DUTY_WIDTH-1:0] r_left_duty;
    logic signed [DUTY_WIDTH-1:0] r_right_duty;

    // block state
    logic [COUNT_WIDTH-1:0] r_period_top;
    logic [COUNT_WIDTH-1:0] r_count,         n_count;
    logic [COUNT_WIDTH-1:0] r_left_pending,  n_left_pending;
    logic [COUNT_WIDTH-1:0] r_right_pending, n_right_pending;
    logic [COUNT_WIDTH-1:0] r_left_active,   n_left_active;
    logic [COUNT_WIDTH-1:0] r_right_active,  n_right_active;
    logic                   r_left_rev,      n_left_rev;
    logic                   r_right_rev,     n_right_rev;
    logic                   r_waiting,       n_waiting;

    // result register
    logic r_out_valid;
    logic r_left_pwm;
    logic r_right_pwm;

    logic       w_fire;
    t_wheel_cmd w_left_cmd;
    t_wheel_cmd w_right_cmd;
    logic [PROD_W-1:0] w_left_prod;
    logic [PROD_W-1:0] w_right_prod;

    // process the held item whenever the result register is free or draining
    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    assign w_left_cmd   = duty_to_cmd(r_left_duty);
    assign w_right_cmd  = duty_to_cmd(r_right_duty);
    assign w_left_prod  = PROD_W'(r_period_top) * PROD_W'(w_left_cmd.mag);
    assign w_right_prod = PROD_W'(r_period_top) * PROD_W'(w_right_cmd.mag);

    always_comb begin
        n_count         = r_count;
        n_left_pending  = r_left_pending;
        n_right_pending = r_right_pending;
        n_left_active   = r_left_active;
        n_right_active  = r_right_active;
        n_left_rev      = r_left_rev;
        n_right_rev     = r_right_rev;
        n_waiting       = r_waiting;
        if (r_op == OP_TICK) begin
            if (r_count >= r_period_top) begin
                // period end: wrap and promote any pending compares
                n_count = '0;
                if (r_waiting) begin
                    n_left_active  = r_left_pending;
                    n_right_active = r_right_pending;
                    n_waiting      = 1'b0;
                end
            end else begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end else begin
            n_left_pending  = w_left_prod[DUTY_FRAC_BITS +: COUNT_WIDTH];
            n_right_pending = w_right_prod[DUTY_FRAC_BITS +: COUNT_WIDTH];
            n_left_rev      = w_left_cmd.rev;
            n_right_rev     = w_right_cmd.rev;
            n_waiting       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_period_top    <= PERIOD_TOP_RESET;
            r_count         <= '0;
            r_left_pending  <= '0;
            r_right_pending <= '0;
            r_left_active   <= '0;
            r_right_active  <= '0;
            r_left_rev      <= 1'b0;
            r_right_rev     <= 1'b0;
            r_waiting       <= 1'b0;
            r_left_pwm      <= 1'b0;
            r_right_pwm     <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_period_top <= i_cfg_period_top;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid     <= 1'b1;
                r_count         <= n_count;
                r_left_pending  <= n_left_pending;
                r_right_pending <= n_right_pending;
                r_left_active   <= n_left_active;
                r_right_active  <= n_right_active;
                r_left_rev      <= n_left_rev;
                r_right_rev     <= n_right_rev;
                r_waiting       <= n_waiting;
                r_left_pwm      <= n_count < n_left_active;
                r_right_pwm     <= n_count < n_right_active;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op         <= i_operation;
            r_left_duty  <= i_left_duty;
            r_right_duty <= i_right_duty;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_pwm      = r_left_pwm;
    assign o_right_pwm     = r_right_pwm;
    assign o_left_reverse  = r_left_rev;
    assign o_right_reverse = r_right_rev;
    assign o_left_compare  = r_left_active;
    assign o_right_compare = r_right_active;

    a_pwm_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_pwm == (r_count < r_left_active))
                     && (o_right_pwm == (r_count < r_right_active)))
        else $error("PWM level disagrees with counter and active compare");

    a_duty_keeps_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_DUTY) |=> $stable(r_left_active) && $stable(r_right_active)
                                        && r_waiting)
        else $error("duty item changed the active compares");

    a_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_op == OP_TICK && r_count >= r_period_top) |=> (r_count == '0) && !r_waiting)
        else $error("period wrap did not reset counter or promote pending compares");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> r_in_valid && $stable(r_op))
        else $error("stalled item lost from input register");

endmodule
